/* hdl/mcmf_pkg.sv */
// mcmf_pkg: types, constants and sequencer states for the min-cost max-flow engine
// used by min_cost_max_flow and its testbench; depends on nothing else
package mcmf_pkg;

  localparam int unsigned MAX_NODES = 256;
  localparam int unsigned MAX_EDGES = 4096;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned CNT_W  = $clog2(MAX_NODES + 1);
  localparam int unsigned EIDX_W = $clog2(MAX_EDGES);
  localparam int unsigned LINK_W = $clog2(MAX_EDGES) + 1;

  localparam logic [LINK_W-1:0] NULL_LINK = '1;
  localparam logic signed [31:0] DIST_INF = 32'sh3f3f3f3f;

  localparam int unsigned PADDR_W = 3;
  localparam logic [PADDR_W-1:0] ADDR_NODE_COUNT = 3'd0;

  typedef enum logic [1:0] {
    MODE_CLEAR = 2'd0,
    MODE_ADD   = 2'd1,
    MODE_SOLVE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2,
    STAT_SAT  = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic [7:0]         node_a;
    logic [7:0]         node_b;
    logic [19:0]        capacity;
    logic signed [15:0] unit_cost;
  } mcmf_in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [31:0]        max_flow;
    logic signed [47:0] total_cost;
  } mcmf_out_t;

  typedef struct packed {
    logic [NODE_W-1:0]  dest;
    logic [LINK_W-1:0]  link;
    logic [19:0]        cap;
    logic signed [20:0] flow;
    logic signed [16:0] cost;
  } edge_rec_t;

  typedef struct packed {
    logic               inq;
    logic [CNT_W-1:0]   hop;
    logic [LINK_W-1:0]  pred;
    logic signed [31:0] path_len;
  } node_rec_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_ADD1, ST_ADD2, ST_ADD3,
    ST_INIT, ST_SEED, ST_POP, ST_POP1, ST_POP2,
    ST_EDGE, ST_E1, ST_E2, ST_CHK, ST_CHK1,
    ST_W1, ST_W2, ST_W3, ST_A1, ST_A2, ST_A3, ST_AF,
    ST_FIN, ST_DONE
  } state_e;

endpackage

/* hdl/mcmf_ram.sv */
// mcmf_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing else
module mcmf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/min_cost_max_flow.sv */
// min_cost_max_flow: edge store with linked adjacency lists and an spfa/augment sequencer
// clear, bad, full and trivial requests go straight to the result; add edge writes the forward
// and the reverse edge record. solve: per path search it inits the live nodes, pops the queue
// and scans each popped node's edges, then walks back from the sink to find the bottleneck
// and again to push; edge and node memories have one read port each. one request at a time
// reset: control, node_count (256), edge count and list head valid bits clear at once
module min_cost_max_flow
  import mcmf_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  mcmf_in_t             in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output mcmf_out_t            out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  state_e state_q, state_d;

  mcmf_in_t           req_q, req_d;
  mcmf_out_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;
  logic [8:0]         node_count_q;
  logic [CNT_W-1:0]   n_q, n_d;
  logic [LINK_W-1:0]  ec_q, ec_d;
  logic [MAX_NODES-1:0] hvld_q, hvld_d;
  logic [1:0]         status_q, status_d;
  logic [31:0]        flow_q, flow_d;
  logic signed [47:0] cost_q, cost_d;
  logic               sat_q, sat_d;
  logic [CNT_W-1:0]   idx_q, idx_d;
  logic [NODE_W-1:0]  u_q, u_d, v_q, v_d;
  logic signed [31:0] du_q, du_d, nd_q, nd_d;
  logic [CNT_W-1:0]   hu_q, hu_d;
  logic [LINK_W-1:0]  e_q, e_d, lk_q, lk_d;
  logic [NODE_W-1:0]  qh_q, qh_d, qt_q, qt_d;
  logic [CNT_W-1:0]   ql_q, ql_d;
  logic signed [21:0] push_q, push_d;
  logic signed [38:0] prod_q, prod_d;

  logic               edge_we;
  logic [EIDX_W-1:0]  edge_waddr, edge_raddr;
  edge_rec_t          edge_wdata, edge_rd;
  logic               node_we;
  logic [NODE_W-1:0]  node_waddr, node_raddr;
  node_rec_t          node_wdata, node_rd;
  logic               head_we;
  logic [NODE_W-1:0]  head_waddr, head_raddr;
  logic [LINK_W-1:0]  head_wdata, head_rd;
  logic               queue_we;
  logic [NODE_W-1:0]  queue_waddr, queue_raddr;
  logic [NODE_W-1:0]  queue_wdata, queue_rd;

  logic [CNT_W-1:0]   n_live;
  logic               in_bad, req_bad, add_full;
  logic signed [21:0] res;
  logic               res_nonpos;
  logic               dest_bad;
  logic [LINK_W-1:0]  e_pair, pred_pair;
  logic [CNT_W-1:0]   hop_new;
  logic signed [48:0] csum;
  logic [32:0]        fsum;
  logic signed [16:0] fwd_cost;
  logic               accept;

  mcmf_ram #(.WIDTH($bits(edge_rec_t)), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk_i, .we_i(edge_we), .waddr_i(edge_waddr), .wdata_i(edge_wdata),
    .raddr_i(edge_raddr), .rdata_o(edge_rd)
  );

  mcmf_ram #(.WIDTH($bits(node_rec_t)), .DEPTH(MAX_NODES)) u_node_ram (
    .clk_i, .we_i(node_we), .waddr_i(node_waddr), .wdata_i(node_wdata),
    .raddr_i(node_raddr), .rdata_o(node_rd)
  );

  mcmf_ram #(.WIDTH(LINK_W), .DEPTH(MAX_NODES)) u_head_ram (
    .clk_i, .we_i(head_we), .waddr_i(head_waddr), .wdata_i(head_wdata),
    .raddr_i(head_raddr), .rdata_o(head_rd)
  );

  mcmf_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue_ram (
    .clk_i, .we_i(queue_we), .waddr_i(queue_waddr), .wdata_i(queue_wdata),
    .raddr_i(queue_raddr), .rdata_o(queue_rd)
  );

  // configuration port
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_NODE_COUNT) ? {23'd0, node_count_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 9'(MAX_NODES);
    end else if (psel && penable && pwrite && (paddr == ADDR_NODE_COUNT)) begin
      node_count_q <= pwdata[8:0];
    end
  end

  // shared helpers
  assign n_live     = (node_count_q > 9'(MAX_NODES)) ? CNT_W'(MAX_NODES)
                                                     : CNT_W'(node_count_q);
  assign in_bad     = (CNT_W'(in_data_i.node_a) >= n_live) ||
                      (CNT_W'(in_data_i.node_b) >= n_live);
  assign req_bad    = in_bad;
  assign add_full   = ({1'b0, ec_q} + (LINK_W+1)'(2)) > (LINK_W+1)'(MAX_EDGES);
  assign accept     = in_valid_i && in_ready_o;
  assign res        = $signed({2'b00, edge_rd.cap}) - $signed({edge_rd.flow[20], edge_rd.flow});
  assign res_nonpos = res[21] || (res == 22'sd0);
  assign dest_bad   = CNT_W'(edge_rd.dest) >= n_q;
  assign e_pair     = {e_q[LINK_W-1:1], ~e_q[0]};
  assign pred_pair  = {node_rd.pred[LINK_W-1:1], ~node_rd.pred[0]};
  assign hop_new    = hu_q + CNT_W'(1);
  assign csum       = $signed({cost_q[47], cost_q}) + $signed({{10{prod_q[38]}}, prod_q});
  assign fsum       = {1'b0, flow_q} + 33'(push_q[20:0]);
  assign fwd_cost   = $signed({req_q.unit_cost[15], req_q.unit_cost});

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (mode_e'(in_data_i.mode))
            MODE_ADD:   state_d = (req_bad || add_full) ? ST_DONE : ST_ADD1;
            MODE_SOLVE: state_d = (req_bad || (in_data_i.node_a == in_data_i.node_b))
                                  ? ST_DONE : ST_INIT;
            default:    state_d = ST_DONE;
          endcase
        end
      end
      ST_ADD1: state_d = ST_ADD2;
      ST_ADD2: state_d = ST_ADD3;
      ST_ADD3: state_d = ST_DONE;
      ST_INIT: if (idx_q == n_q - CNT_W'(1)) state_d = ST_SEED;
      ST_SEED: state_d = ST_POP;
      ST_POP:  state_d = (ql_q == '0) ? ST_CHK : ST_POP1;
      ST_POP1: state_d = ST_POP2;
      ST_POP2: state_d = ST_EDGE;
      ST_EDGE: state_d = (e_q >= ec_q) ? ST_POP : ST_E1;
      ST_E1:   state_d = (dest_bad || res_nonpos) ? ST_EDGE : ST_E2;
      ST_E2: begin
        if ((node_rd.path_len > nd_q) && (hop_new >= n_q)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_EDGE;
        end
      end
      ST_CHK:  state_d = ST_CHK1;
      ST_CHK1: state_d = (node_rd.pred == NULL_LINK) ? ST_FIN : ST_W1;
      ST_W1: begin
        if ((node_rd.pred >= ec_q) || (pred_pair >= ec_q) || (idx_q >= n_q)) begin
          state_d = ST_FIN;
        end else begin
          state_d = ST_W2;
        end
      end
      ST_W2:   state_d = ST_W3;
      ST_W3: begin
        if (dest_bad) begin
          state_d = ST_FIN;
        end else if (edge_rd.dest == req_q.node_a) begin
          state_d = (push_q[21] || (push_q == 22'sd0)) ? ST_FIN : ST_A1;
        end else begin
          state_d = ST_W1;
        end
      end
      ST_A1:   state_d = ST_A2;
      ST_A2:   state_d = ST_A3;
      ST_A3:   state_d = (edge_rd.dest == req_q.node_a) ? ST_AF : ST_A1;
      ST_AF:   state_d = ST_INIT;
      ST_FIN:  state_d = ST_DONE;
      ST_DONE: if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    req_d       = req_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    n_d         = n_q;
    ec_d        = ec_q;
    hvld_d      = hvld_q;
    status_d    = status_q;
    flow_d      = flow_q;
    cost_d      = cost_q;
    sat_d       = sat_q;
    idx_d       = idx_q;
    u_d         = u_q;
    v_d         = v_q;
    du_d        = du_q;
    nd_d        = nd_q;
    hu_d        = hu_q;
    e_d         = e_q;
    lk_d        = lk_q;
    qh_d        = qh_q;
    qt_d        = qt_q;
    ql_d        = ql_q;
    push_d      = push_q;
    prod_d      = prod_q;

    edge_we     = 1'b0;
    edge_waddr  = e_q[EIDX_W-1:0];
    edge_wdata  = edge_rd;
    edge_raddr  = e_q[EIDX_W-1:0];
    node_we     = 1'b0;
    node_waddr  = v_q;
    node_wdata  = node_rd;
    node_raddr  = v_q;
    head_we     = 1'b0;
    head_waddr  = req_q.node_a;
    head_wdata  = ec_q;
    head_raddr  = req_q.node_b;
    queue_we    = 1'b0;
    queue_waddr = qt_q;
    queue_wdata = v_q;
    queue_raddr = qh_q;

    unique case (state_q)
      ST_IDLE: begin
        head_raddr = in_data_i.node_a;
        if (accept) begin
          req_d    = in_data_i;
          n_d      = n_live;
          flow_d   = '0;
          cost_d   = '0;
          sat_d    = 1'b0;
          idx_d    = '0;
          status_d = STAT_OK;
          case (mode_e'(in_data_i.mode))
            MODE_CLEAR: begin
              ec_d   = '0;
              hvld_d = '0;
            end
            MODE_ADD: begin
              if (req_bad) status_d = STAT_BAD;
              else if (add_full) status_d = STAT_FULL;
            end
            MODE_SOLVE: begin
              if (req_bad) status_d = STAT_BAD;
            end
            default: status_d = STAT_OK;
          endcase
        end
      end
      ST_ADD1: begin
        edge_we         = 1'b1;
        edge_waddr      = ec_q[EIDX_W-1:0];
        edge_wdata.dest = req_q.node_b;
        edge_wdata.link = hvld_q[req_q.node_a] ? head_rd : NULL_LINK;
        edge_wdata.cap  = req_q.capacity;
        edge_wdata.flow = '0;
        edge_wdata.cost = fwd_cost;
        head_we         = 1'b1;
        head_waddr      = req_q.node_a;
        head_wdata      = ec_q;
        hvld_d[req_q.node_a] = 1'b1;
      end
      ST_ADD2: head_raddr = req_q.node_b;
      ST_ADD3: begin
        edge_we         = 1'b1;
        edge_waddr      = ec_q[EIDX_W-1:0] + EIDX_W'(1);
        edge_wdata.dest = req_q.node_a;
        edge_wdata.link = hvld_q[req_q.node_b] ? head_rd : NULL_LINK;
        edge_wdata.cap  = '0;
        edge_wdata.flow = '0;
        edge_wdata.cost = -fwd_cost;
        head_we         = 1'b1;
        head_waddr      = req_q.node_b;
        head_wdata      = ec_q + LINK_W'(1);
        hvld_d[req_q.node_b] = 1'b1;
        ec_d            = ec_q + LINK_W'(2);
      end
      ST_INIT: begin
        node_we    = 1'b1;
        node_waddr = idx_q[NODE_W-1:0];
        node_wdata = '{inq: 1'b0, hop: '0, pred: NULL_LINK, path_len: DIST_INF};
        idx_d      = idx_q + CNT_W'(1);
      end
      ST_SEED: begin
        node_we     = 1'b1;
        node_waddr  = req_q.node_a;
        node_wdata  = '{inq: 1'b1, hop: '0, pred: NULL_LINK, path_len: 32'sd0};
        queue_we    = 1'b1;
        queue_waddr = '0;
        queue_wdata = req_q.node_a;
        qh_d        = '0;
        qt_d        = NODE_W'(1);
        ql_d        = CNT_W'(1);
      end
      ST_POP: begin
        queue_raddr = qh_q;
        if (ql_q != '0) begin
          qh_d = qh_q + NODE_W'(1);
          ql_d = ql_q - CNT_W'(1);
        end
        node_raddr = req_q.node_b;
      end
      ST_POP1: begin
        u_d        = queue_rd;
        node_raddr = queue_rd;
        head_raddr = queue_rd;
      end
      ST_POP2: begin
        du_d           = node_rd.path_len;
        hu_d           = node_rd.hop;
        node_we        = 1'b1;
        node_waddr     = u_q;
        node_wdata     = node_rd;
        node_wdata.inq = 1'b0;
        e_d            = hvld_q[u_q] ? head_rd : NULL_LINK;
      end
      ST_EDGE: edge_raddr = e_q[EIDX_W-1:0];
      ST_E1: begin
        lk_d       = edge_rd.link;
        v_d        = edge_rd.dest;
        nd_d       = du_q + 32'(edge_rd.cost);
        node_raddr = edge_rd.dest;
        if (dest_bad || res_nonpos) e_d = edge_rd.link;
      end
      ST_E2: begin
        e_d = lk_q;
        if (node_rd.path_len > nd_q) begin
          if (hop_new >= n_q) begin
            sat_d = 1'b1;
          end else begin
            node_we             = 1'b1;
            node_waddr          = v_q;
            node_wdata.inq      = node_rd.inq;
            node_wdata.hop      = hop_new;
            node_wdata.pred     = e_q;
            node_wdata.path_len = nd_q;
            if (!node_rd.inq && (ql_q < CNT_W'(MAX_NODES))) begin
              node_wdata.inq = 1'b1;
              queue_we       = 1'b1;
              queue_waddr    = qt_q;
              queue_wdata    = v_q;
              qt_d           = qt_q + NODE_W'(1);
              ql_d           = ql_q + CNT_W'(1);
            end
            if (v_q == u_q) begin
              du_d = nd_q;
              hu_d = hop_new;
            end
          end
        end
      end
      ST_CHK: node_raddr = req_q.node_b;
      ST_CHK1: begin
        node_raddr = req_q.node_b;
        idx_d      = '0;
        push_d     = 22'sd1048576;
        v_d        = req_q.node_b;
      end
      ST_W1: begin
        e_d        = node_rd.pred;
        edge_raddr = node_rd.pred[EIDX_W-1:0];
        if ((node_rd.pred >= ec_q) || (pred_pair >= ec_q) || (idx_q >= n_q)) begin
          sat_d = 1'b1;
        end
      end
      ST_W2: begin
        if (res < push_q) push_d = res;
        edge_raddr = e_pair[EIDX_W-1:0];
      end
      ST_W3: begin
        idx_d      = idx_q + CNT_W'(1);
        v_d        = edge_rd.dest;
        node_raddr = edge_rd.dest;
        if (dest_bad) begin
          sat_d = 1'b1;
        end else if (edge_rd.dest == req_q.node_a) begin
          node_raddr = req_q.node_b;
          if (push_q[21] || (push_q == 22'sd0)) sat_d = 1'b1;
        end
      end
      ST_A1: begin
        e_d        = node_rd.pred;
        edge_raddr = node_rd.pred[EIDX_W-1:0];
      end
      ST_A2: begin
        edge_we         = 1'b1;
        edge_waddr      = e_q[EIDX_W-1:0];
        edge_wdata      = edge_rd;
        edge_wdata.flow = edge_rd.flow + push_q[20:0];
        prod_d          = $signed({{22{edge_rd.cost[16]}}, edge_rd.cost}) *
                          $signed({{17{push_q[21]}}, push_q});
        edge_raddr      = e_pair[EIDX_W-1:0];
      end
      ST_A3: begin
        edge_we         = 1'b1;
        edge_waddr      = e_pair[EIDX_W-1:0];
        edge_wdata      = edge_rd;
        edge_wdata.flow = edge_rd.flow - push_q[20:0];
        node_raddr      = edge_rd.dest;
        if (csum[48] != csum[47]) begin
          sat_d  = 1'b1;
          cost_d = csum[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
        end else begin
          cost_d = csum[47:0];
        end
      end
      ST_AF: begin
        idx_d = '0;
        if (fsum[32]) begin
          flow_d = '1;
          sat_d  = 1'b1;
        end else begin
          flow_d = fsum[31:0];
        end
      end
      ST_FIN: status_d = sat_q ? STAT_SAT : STAT_OK;
      ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d      = 1'b1;
          out_d.status     = status_q;
          out_d.max_flow   = flow_q;
          out_d.total_cost = cost_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      ec_q        <= '0;
      hvld_q      <= '0;
      ql_q        <= '0;
      qh_q        <= '0;
      qt_q        <= '0;
      sat_q       <= 1'b0;
      idx_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      ec_q        <= ec_d;
      hvld_q      <= hvld_d;
      ql_q        <= ql_d;
      qh_q        <= qh_d;
      qt_q        <= qt_d;
      sat_q       <= sat_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q    <= req_d;
    out_q    <= out_d;
    n_q      <= n_d;
    status_q <= status_d;
    flow_q   <= flow_d;
    cost_q   <= cost_d;
    u_q      <= u_d;
    v_q      <= v_d;
    du_q     <= du_d;
    nd_q     <= nd_d;
    hu_q     <= hu_d;
    e_q      <= e_d;
    lk_q     <= lk_d;
    push_q   <= push_d;
    prod_q   <= prod_d;
  end

  a_ql_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ql_q <= CNT_W'(MAX_NODES))
    else $error("node queue overfilled");

  a_ec_pairs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ec_q[0] && (ec_q <= LINK_W'(MAX_EDGES)))
    else $error("edge count not paired or beyond store");

  a_push_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_A1) |-> (push_q > 22'sd0))
    else $error("augment with empty bottleneck");

  a_seed_nodes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEED) |-> (req_q.node_a != req_q.node_b))
    else $error("solve started with source equal to sink");

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("request taken while busy");

endmodule

/* tb/sv/tb_min_cost_max_flow.sv */
// tb_min_cost_max_flow: self-checking testbench for the min-cost max-flow engine
// holds its own flow predictor and result scoreboard; depends on mcmf_pkg and the block
`timescale 1ns / 1ps

module tb_min_cost_max_flow;
  import mcmf_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 6_000_000;
  localparam int unsigned NO_EDGE = 32'hFFFF_FFFF;
  localparam longint COST_TOP = 64'sd140737488355327;
  localparam longint COST_BOTTOM = -COST_TOP - 1;

  class flow_scoreboard;
    int unsigned node_limit;
    int unsigned edge_head[MAX_EDGES];
    int unsigned edge_next[MAX_EDGES];
    longint edge_cap[MAX_EDGES];
    longint edge_used[MAX_EDGES];
    longint edge_price[MAX_EDGES];
    int unsigned first_edge[MAX_NODES];
    int unsigned edges_stored;
    longint path_len[MAX_NODES];
    bit queued[MAX_NODES];
    int unsigned via_edge[MAX_NODES];
    int unsigned hops[MAX_NODES];
    int unsigned ring[MAX_NODES];
    mcmf_out_t awaited[$];
    int errors;

    function new();
      node_limit = 256;
      edges_stored = 0;
      errors = 0;
      for (int i = 0; i < MAX_NODES; i++) begin
        first_edge[i] = NO_EDGE;
        queued[i] = 1'b0;
      end
    endfunction

    function longint spare(int unsigned e);
      return edge_cap[e] - edge_used[e];
    endfunction

    // returns 0 if the sink is unreachable, 1 if a path is found, 2 if a negative-cost loop is found
    function int shortest_path(int unsigned src, int unsigned dst, int unsigned n);
      int unsigned qh, qt, ql, u, e, v;
      longint nd;
      qh = 0;
      qt = 0;
      for (int i = 0; i < n; i++) begin
        path_len[i] = DIST_INF;
        queued[i] = 1'b0;
        via_edge[i] = NO_EDGE;
        hops[i] = 0;
      end
      path_len[src] = 0;
      queued[src] = 1'b1;
      ring[qt] = src;
      qt = (qt + 1) % MAX_NODES;
      ql = 1;
      while (ql > 0) begin
        u = ring[qh];
        qh = (qh + 1) % MAX_NODES;
        ql--;
        queued[u] = 1'b0;
        e = first_edge[u];
        while (e < edges_stored) begin
          v = edge_head[e];
          if (v < n && spare(e) > 0) begin
            nd = path_len[u] + edge_price[e];
            if (path_len[v] > nd) begin
              path_len[v] = nd;
              via_edge[v] = e;
              hops[v] = hops[u] + 1;
              if (hops[v] >= n) return 2;
              if (!queued[v] && ql < MAX_NODES) begin
                queued[v] = 1'b1;
                ring[qt] = v;
                qt = (qt + 1) % MAX_NODES;
                ql++;
              end
            end
          end
          e = edge_next[e];
        end
      end
      return (via_edge[dst] != NO_EDGE) ? 1 : 0;
    endfunction

    function void augment_all(input int unsigned src, input int unsigned dst,
                              input int unsigned n, output logic [1:0] stat,
                              output longint flow, output longint cost);
      int r;
      int unsigned v, e, steps;
      longint push, sum;
      bit sat, broken;
      flow = 0;
      cost = 0;
      sat = 1'b0;
      forever begin
        r = shortest_path(src, dst, n);
        push = DIST_INF;
        broken = 1'b0;
        if (r == 0) break;
        if (r == 2) begin
          sat = 1'b1;
          break;
        end
        v = dst;
        steps = 0;
        while (v != src) begin
          e = via_edge[v];
          if (e >= edges_stored || (e ^ 1) >= edges_stored || steps >= n) begin
            broken = 1'b1;
            break;
          end
          if (spare(e) < push) push = spare(e);
          v = edge_head[e ^ 1];
          if (v >= n) begin
            broken = 1'b1;
            break;
          end
          steps++;
        end
        if (broken || push <= 0) begin
          sat = 1'b1;
          break;
        end
        v = dst;
        while (v != src) begin
          e = via_edge[v];
          edge_used[e] += push;
          edge_used[e ^ 1] -= push;
          sum = cost + edge_price[e] * push;
          if (sum > COST_TOP) begin
            sat = 1'b1;
            sum = COST_TOP;
          end else if (sum < COST_BOTTOM) begin
            sat = 1'b1;
            sum = COST_BOTTOM;
          end
          cost = sum;
          v = edge_head[e ^ 1];
        end
        flow += push;
        if (flow > 64'hFFFF_FFFF) begin
          flow = 64'hFFFF_FFFF;
          sat = 1'b1;
        end
      end
      stat = sat ? STAT_SAT : STAT_OK;
    endfunction

    function void note_request(mcmf_in_t r);
      mcmf_out_t res;
      int unsigned n, a, b, f;
      longint flow, cost, price;
      logic [1:0] stat;
      n = (node_limit > MAX_NODES) ? MAX_NODES : node_limit;
      a = r.node_a;
      b = r.node_b;
      price = longint'($signed(r.unit_cost));
      stat = STAT_OK;
      flow = 0;
      cost = 0;
      if (r.mode == MODE_CLEAR) begin
        edges_stored = 0;
        for (int i = 0; i < MAX_NODES; i++) first_edge[i] = NO_EDGE;
      end else if (r.mode == MODE_ADD) begin
        if (a >= n || b >= n) begin
          stat = STAT_BAD;
        end else if (edges_stored + 2 > MAX_EDGES) begin
          stat = STAT_FULL;
        end else begin
          f = edges_stored;
          edge_head[f] = b;
          edge_cap[f] = r.capacity;
          edge_price[f] = price;
          edge_used[f] = 0;
          edge_next[f] = first_edge[a];
          first_edge[a] = f;
          edge_head[f + 1] = a;
          edge_cap[f + 1] = 0;
          edge_price[f + 1] = -price;
          edge_used[f + 1] = 0;
          edge_next[f + 1] = first_edge[b];
          first_edge[b] = f + 1;
          edges_stored += 2;
        end
      end else if (r.mode == MODE_SOLVE) begin
        if (a >= n || b >= n) stat = STAT_BAD;
        else if (a != b) augment_all(a, b, n, stat, flow, cost);
      end
      res.status = stat;
      res.max_flow = flow[31:0];
      res.total_cost = cost[47:0];
      awaited.push_back(res);
    endfunction

    function void check(mcmf_out_t got);
      mcmf_out_t want;
      if (awaited.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.max_flow !== want.max_flow) begin
        $display("%0t: max_flow expected %0d actual %0d", $time, want.max_flow, got.max_flow);
        errors++;
      end
      if (got.total_cost !== want.total_cost) begin
        $display("%0t: total_cost expected %0d actual %0d", $time, want.total_cost,
                 got.total_cost);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  mcmf_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  mcmf_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  flow_scoreboard sb = new();
  bit calm = 1'b0;
  bit hold_off = 1'b0;
  int unsigned cycles = 0;

  min_cost_max_flow i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // result side: random stalls, one long hold-off on request
  initial begin
    int unsigned stall;
    int r;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid && out_ready) sb.check(out_data);
      if (hold_off) begin
        hold_off = 1'b0;
        out_ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end else if (calm) begin
        out_ready <= 1'b1;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else begin
        out_ready <= 1'b1;
        r = $urandom_range(0, 99);
        if (r < 20) stall = $urandom_range(1, 3);
        else if (r < 23) stall = $urandom_range(10, 50);
      end
    end
  end

  function automatic mcmf_in_t request(logic [1:0] mode, int unsigned a, int unsigned b,
                                       int unsigned cap, int cost);
    mcmf_in_t r;
    r.mode = mode;
    r.node_a = a[7:0];
    r.node_b = b[7:0];
    r.capacity = cap[19:0];
    r.unit_cost = cost[15:0];
    return r;
  endfunction

  task automatic send(input mcmf_in_t r);
    int unsigned gap, p;
    gap = 0;
    if (!calm) begin
      p = $urandom_range(0, 99);
      if (p >= 92) gap = $urandom_range(8, 40);
      else if (p >= 65) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk_i); while (!in_ready);
    sb.note_request(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic set_node_count(input int unsigned v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_NODE_COUNT;
    pwdata <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    sb.node_limit = v & 32'h1FF;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== (v & 32'h1FF)) begin
      $display("%0t: node_count read expected %0d actual %0d", $time, v, prdata);
      sb.errors++;
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  function automatic int unsigned pick_node(int unsigned n);
    if (n <= 16) return $urandom_range(0, n - 1);
    return $urandom_range(0, 1) ? $urandom_range(0, 7) : $urandom_range(248, 255);
  endfunction

  function automatic int unsigned pick_capacity();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 10) return 0;
    if (p < 18) return 20'hFFFFF;
    if (p < 33) return $urandom_range(0, 20'hFFFFF);
    return $urandom_range(1, 20);
  endfunction

  // a phase adds a fresh graph, then only solves, so residuals keep no negative cycle
  task automatic run_phase(input int unsigned ph);
    int unsigned n, adds, solves, a, b, t, p;
    logic [1:0] m;
    int cost;
    bit acyclic;
    p = $urandom_range(0, 99);
    if (p < 8) n = 256;
    else if (p < 14) n = 1;
    else n = $urandom_range(2, 12);
    acyclic = $urandom_range(0, 1);
    wait_idle();
    calm = ($urandom_range(0, 3) == 0);
    set_node_count(n);
    if (ph == 5) hold_off = 1'b1;
    send(request(MODE_CLEAR, $urandom, $urandom, $urandom, $urandom));
    adds = $urandom_range(3, (n < 10) ? 3 * n + 3 : 30);
    for (int i = 0; i < adds; i++) begin
      a = pick_node(n);
      b = pick_node(n);
      cost = $urandom_range(0, 32767);
      if (acyclic) begin
        if (a > b) begin
          t = a;
          a = b;
          b = t;
        end
        if (a != b) begin
          p = $urandom_range(0, 9);
          if (p == 0) cost = -32768;
          else if (p == 1) cost = 32767;
          else cost = $urandom_range(0, 65535) - 32768;
        end
      end
      p = $urandom_range(0, 19);
      if (p == 0 && n < 256) a = $urandom_range(n, 255);
      else if (p == 1 && n < 256) b = $urandom_range(n, 255);
      m = ($urandom_range(0, 29) == 0) ? 2'd3 : MODE_ADD;
      send(request(m, a, b, pick_capacity(), cost));
    end
    solves = $urandom_range(1, 4);
    for (int i = 0; i < solves; i++) begin
      a = pick_node(n);
      b = pick_node(n);
      if ($urandom_range(0, 9) == 0 && n < 256) b = $urandom_range(n, 255);
      send(request(MODE_SOLVE, a, b, $urandom, $urandom));
    end
    if (n > 1 && $urandom_range(0, 2) == 0) begin
      wait_idle();
      t = $urandom_range(1, n - 1);
      set_node_count(t);
      repeat (2) send(request(MODE_SOLVE, pick_node(n), pick_node(n), 0, 0));
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_node_count(256);
    send(request(MODE_CLEAR, 0, 0, 0, 0));
    send(request(MODE_ADD, 0, 255, 20'hFFFFF, -32768));
    send(request(MODE_ADD, 0, 1, 0, 32767));
    send(request(MODE_ADD, 1, 255, 5, 0));
    send(request(MODE_ADD, 0, 2, 2, 10));
    send(request(MODE_ADD, 2, 255, 7, 100));
    send(request(MODE_SOLVE, 0, 255, 0, 0));
    send(request(MODE_SOLVE, 255, 0, 0, 0));
    send(request(MODE_SOLVE, 7, 7, 0, 0));
    send(request(2'd3, 255, 255, 20'hFFFFF, -1));
    wait_idle();
    set_node_count(8);
    send(request(MODE_ADD, 9, 0, 1, 1));
    send(request(MODE_ADD, 0, 200, 1, 1));
    send(request(MODE_SOLVE, 0, 200, 0, 0));
    send(request(MODE_ADD, 0, 1, 4, 3));
    send(request(MODE_SOLVE, 0, 2, 0, 0));
    send(request(MODE_SOLVE, 0, 1, 0, 0));
    wait_idle();
    set_node_count(1);
    send(request(MODE_ADD, 0, 0, 4, 3));
    send(request(MODE_SOLVE, 0, 0, 0, 0));
    send(request(MODE_ADD, 0, 1, 4, 3));

    for (int ph = 0; ph < 32; ph++) run_phase(ph);

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
